[rtl/spark_particle_update_defines.svh]
// Assertion macros for the spark particle update block
`ifndef SPARK_PARTICLE_UPDATE_DEFINES_SVH
`define SPARK_PARTICLE_UPDATE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SPU_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spark particle update: same-cycle check failed");
`define SPU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spark particle update: next-cycle check failed");
`else
`define SPU_ASSERT_NOW(label, ante, cons)
`define SPU_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[rtl/spu_pkg.sv]
`default_nettype none
package spu_pkg;

	localparam int unsigned DivBitsPerStage = 4;

	localparam logic [7:0] CfgLifeSpan = 8'd0;
	localparam logic [7:0] CfgSpinRate = 8'd1;

	localparam logic [15:0] LifeSpanReset = 16'd16384;
	localparam logic [31:0] SpinRateReset = 32'd524288;

	localparam logic [16:0] RateOne = 17'h10000;

	localparam logic [15:0] SizeStart  = 16'd29491;
	localparam logic [15:0] SizeDrop   = 16'd26214;
	localparam logic [7:0]  RedValue   = 8'd255;
	localparam logic [7:0]  GreenStart = 8'd191;
	localparam logic [7:0]  GreenDrop  = 8'd114;
	localparam logic [7:0]  BlueStart  = 8'd51;
	localparam logic [7:0]  BlueDrop   = 8'd38;
	localparam logic [7:0]  AlphaStart = 8'd255;
	localparam logic [7:0]  AlphaDrop  = 8'd255;

	typedef struct packed {
		logic [15:0] rem;
		logic [15:0] quot;
	} div_t;

	typedef struct packed {
		logic [31:0] new_pos_x;
		logic [31:0] new_pos_y;
		logic [31:0] new_pos_z;
		logic [31:0] new_angle;
		logic [15:0] age;
		logic        alive;
	} carry_t;

	typedef struct packed {
		logic [15:0] billboard_size;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
	} shade_t;

endpackage
`default_nettype wire

[rtl/spark_particle_update.sv]
`default_nettype none
`include "spark_particle_update_defines.svh"
// Spark particle update: a six-stage pipeline that takes one particle word per
// cycle unless full with the output stalled, and returns it updated. Stage 1
// forms the velocity and spin products and the saturated age, stages 2 to 5 run
// a restoring divider four quotient bits per stage for rate = age / life_span,
// and stage 6 turns the rate into billboard size and color. Each stage moves
// on its own, so bubbles close up and a stalled output holds only the full part
// of the pipe. Write life_span and spin_rate only while the pipe is empty.
module spark_particle_update (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [7:0]   cfg_index,
	input  wire logic [31:0]  cfg_data,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, spin_angle, age_in, delta_time
	input  wire logic [255:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// new_pos_x, new_pos_y, new_pos_z, new_angle, age_out, alive,
	// billboard_size, red, green, blue, alpha, zero fill
	output logic [199:0]      m_axis_tdata
);
	import spu_pkg::*;

	logic [15:0] life_span_q;
	logic [31:0] spin_rate_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;

	logic signed [47:0] prod_s1 [4];
	logic [31:0]        old_s1 [4];
	logic [15:0]        age_s1;
	logic               alive_s1;

	carry_t carry_s2, carry_s3, carry_s4, carry_s5;
	div_t   div_s2, div_s3, div_s4, div_s5;
	carry_t carry_s6;
	shade_t shade_s6;

	logic [15:0] in_dt;
	logic [16:0] age_sum;
	logic [15:0] age_sat;
	logic signed [48:0] mul_full [4];
	logic [31:0] vel_in [4];
	logic [31:0] sum_w [4];
	div_t div_init, div_nx2, div_nx3, div_nx4, div_nx5;
	logic [16:0] rate_w;
	shade_t shade_w;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			life_span_q <= LifeSpanReset;
			spin_rate_q <= SpinRateReset;
		end else if (cfg_valid) begin
			case (cfg_index)
				CfgLifeSpan: life_span_q <= cfg_data[15:0];
				CfgSpinRate: spin_rate_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en_s6 = !valid_s6 || m_axis_tready;
	assign en_s5 = !valid_s5 || en_s6;
	assign en_s4 = !valid_s4 || en_s5;
	assign en_s3 = !valid_s3 || en_s4;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;
	assign s_axis_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= s_axis_tvalid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
			if (en_s5) valid_s5 <= valid_s4;
			if (en_s6) valid_s6 <= valid_s5;
		end
	end

	always_comb begin
		in_dt     = s_axis_tdata[255:240];
		age_sum   = {1'b0, s_axis_tdata[239:224]} + {1'b0, in_dt};
		age_sat   = age_sum[16] ? 16'hffff : age_sum[15:0];
		vel_in[0] = s_axis_tdata[127:96];
		vel_in[1] = s_axis_tdata[159:128];
		vel_in[2] = s_axis_tdata[191:160];
		vel_in[3] = spin_rate_q;
		for (int i = 0; i < 4; i++) begin
			mul_full[i] = $signed(vel_in[i]) * $signed({1'b0, in_dt});
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int i = 0; i < 4; i++) begin
				prod_s1[i] <= mul_full[i][47:0];
			end
			old_s1[0] <= s_axis_tdata[31:0];
			old_s1[1] <= s_axis_tdata[63:32];
			old_s1[2] <= s_axis_tdata[95:64];
			old_s1[3] <= s_axis_tdata[223:192];
			age_s1    <= age_sat;
			alive_s1  <= age_sat < life_span_q;
		end
	end

	for (genvar g = 0; g < 4; g++) begin : g_integ
		spu_sat_add u_sat_add (
			.prod (prod_s1[g]),
			.old  (old_s1[g]),
			.sum  (sum_w[g])
		);
	end

	assign div_init.rem  = age_s1;
	assign div_init.quot = '0;

	spu_div_step u_div_s2 (.divisor(life_span_q), .div_in(div_init), .div_out(div_nx2));
	spu_div_step u_div_s3 (.divisor(life_span_q), .div_in(div_s2),   .div_out(div_nx3));
	spu_div_step u_div_s4 (.divisor(life_span_q), .div_in(div_s3),   .div_out(div_nx4));
	spu_div_step u_div_s5 (.divisor(life_span_q), .div_in(div_s4),   .div_out(div_nx5));

	always_ff @(posedge clk) begin
		if (en_s2) begin
			carry_s2.new_pos_x <= sum_w[0];
			carry_s2.new_pos_y <= sum_w[1];
			carry_s2.new_pos_z <= sum_w[2];
			carry_s2.new_angle <= sum_w[3];
			carry_s2.age       <= age_s1;
			carry_s2.alive     <= alive_s1;
			div_s2             <= div_nx2;
		end
		if (en_s3) begin
			carry_s3 <= carry_s2;
			div_s3   <= div_nx3;
		end
		if (en_s4) begin
			carry_s4 <= carry_s3;
			div_s4   <= div_nx4;
		end
		if (en_s5) begin
			carry_s5 <= carry_s4;
			div_s5   <= div_nx5;
		end
	end

	assign rate_w = carry_s5.alive ? {1'b0, div_s5.quot} : RateOne;

	spu_shade u_shade (
		.rate  (rate_w),
		.shade (shade_w)
	);

	always_ff @(posedge clk) begin
		if (en_s6) begin
			carry_s6 <= carry_s5;
			shade_s6 <= shade_w;
		end
	end

	assign m_axis_tvalid = valid_s6;
	assign m_axis_tdata  = {7'd0, shade_s6.alpha, shade_s6.blue, shade_s6.green,
		shade_s6.red, shade_s6.billboard_size, carry_s6.alive, carry_s6.age,
		carry_s6.new_angle, carry_s6.new_pos_z, carry_s6.new_pos_y,
		carry_s6.new_pos_x};

	`SPU_ASSERT_NOW(a_dead_fades, valid_s6 && !carry_s6.alive,
		shade_s6.billboard_size == 16'd3277 && shade_s6.alpha == 8'd0)
	`SPU_ASSERT_NOW(a_alive_age, valid_s6 && carry_s6.alive, carry_s6.age < life_span_q)
	`SPU_ASSERT_NOW(a_full_stall, valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5 &&
		valid_s6 && !m_axis_tready, !s_axis_tready)
	`SPU_ASSERT_NEXT(a_out_hold, valid_s6 && !m_axis_tready, valid_s6 && $stable(carry_s6))

endmodule
`default_nettype wire

[rtl/spu_div_step.sv]
`default_nettype none
module spu_div_step (
	input  wire logic [15:0]  divisor,
	input  wire spu_pkg::div_t div_in,
	output spu_pkg::div_t      div_out
);
	import spu_pkg::*;

	always_comb begin
		logic [16:0] trial;
		logic [15:0] rem;
		logic [15:0] quot;
		rem  = div_in.rem;
		quot = div_in.quot;
		for (int i = 0; i < int'(DivBitsPerStage); i++) begin
			trial = {rem, 1'b0};
			if (trial >= {1'b0, divisor}) begin
				trial = trial - {1'b0, divisor};
				quot  = {quot[14:0], 1'b1};
			end else begin
				quot  = {quot[14:0], 1'b0};
			end
			rem = trial[15:0];
		end
		div_out.rem  = rem;
		div_out.quot = quot;
	end

endmodule
`default_nettype wire

[rtl/spu_sat_add.sv]
`default_nettype none
module spu_sat_add (
	input  wire logic signed [47:0] prod,
	input  wire logic [31:0]        old,
	output logic [31:0]             sum
);
	import spu_pkg::*;

	logic signed [47:0] biased;
	logic [31:0]        stp;
	logic [32:0]        wide;

	always_comb begin
		biased = prod + 48'sd32768;
		stp    = 32'(biased >>> 16);
		wide   = {old[31], old} + {stp[31], stp};
		if (wide[32] != wide[31]) begin
			sum = wide[32] ? 32'h8000_0000 : 32'h7fff_ffff;
		end else begin
			sum = wide[31:0];
		end
	end

endmodule
`default_nettype wire

[rtl/spu_shade.sv]
`default_nettype none
module spu_shade (
	input  wire logic [16:0] rate,
	output spu_pkg::shade_t   shade
);
	import spu_pkg::*;

	function automatic logic [15:0] lerp_down(logic [15:0] start, logic [15:0] drop,
			logic [16:0] r);
		logic [32:0] p;
		p = {17'd0, drop} * {16'd0, r};
		p = p + 33'd32768;
		return start - p[31:16];
	endfunction

	logic [15:0] green_w;
	logic [15:0] blue_w;
	logic [15:0] alpha_w;

	always_comb begin
		green_w              = lerp_down({8'd0, GreenStart}, {8'd0, GreenDrop}, rate);
		blue_w               = lerp_down({8'd0, BlueStart}, {8'd0, BlueDrop}, rate);
		alpha_w              = lerp_down({8'd0, AlphaStart}, {8'd0, AlphaDrop}, rate);
		shade.billboard_size = lerp_down(SizeStart, SizeDrop, rate);
		shade.red            = RedValue;
		shade.green          = green_w[7:0];
		shade.blue           = blue_w[7:0];
		shade.alpha          = alpha_w[7:0];
	end

endmodule
`default_nettype wire
